// ===== rtl/transverse_momentum_sums_unit_defines.svh =====
// Assertion macros shared by the transverse momentum sums RTL.
`ifndef TRANSVERSE_MOMENTUM_SUMS_UNIT_DEFINES_SVH
`define TRANSVERSE_MOMENTUM_SUMS_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define TMS_CHECK(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("transverse momentum sums: check failed");

// Next-cycle implication, checked outside reset.
`define TMS_CHECK_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("transverse momentum sums: next-cycle check failed");

`endif

// ===== rtl/tms_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tms_pkg
// Constants and types for the transverse momentum sums unit.
// ----------------------------------------------------------------------------
package tms_pkg;

    localparam int PDG_W    = 25;
    localparam int STATUS_W = 8;
    localparam int MOM_W    = 32;
    localparam int ENERGY_W = 31;
    localparam int OUT_W    = 41;

    localparam logic signed [PDG_W-1:0] PDG_ELECTRON = 25'sd11;
    localparam logic signed [PDG_W-1:0] PDG_POSITRON = -25'sd11;
    localparam logic [STATUS_W-1:0]     STATUS_FINAL = 8'd1;

    // Operand magnitudes fed to the hypotenuse unit, their squares and root.
    localparam int OP_W   = 45;
    localparam int SQ_W   = 2 * OP_W;
    localparam int ROOT_W = OP_W;
    localparam int REM_W  = ROOT_W + 3;
    localparam int HI_W   = OP_W - MOM_W;

    localparam logic [OUT_W-1:0] OUT_MAX   = {OUT_W{1'b1}};
    localparam logic [63:0]      OUT_MAX64 = 64'(OUT_MAX);

    // Partial product positions within a square.
    localparam logic [1:0] PART_LL = 2'd0;
    localparam logic [1:0] PART_HL = 2'd1;
    localparam logic [1:0] PART_HH = 2'd2;
    localparam int SH_HL = 33;
    localparam int SH_HH = 64;

    typedef struct packed {
        logic [ENERGY_W-1:0] energy;
        logic [MOM_W-1:0]    py;
        logic [MOM_W-1:0]    px;
    } t_particle;

endpackage

// ===== rtl/transverse_momentum_sums_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// transverse_momentum_sums_unit
// Missing transverse momentum and scalar pT sum over the final-state
// particles of one event, less any whose energy matches the top electron or positron.
// ----------------------------------------------------------------------------
// Channel   Dir  Contents
// s side    in   tuser {gen_status, pdg_code}, tdata {energy, mom_y, mom_x}, tlast
// m side    out  tdata {scalar_sum, vector_sum_mag}, tuser overflow
//
// A particle that is not the last of its event is taken while idle and starts no pass.
// The last particle starts a pass over the store: each kept particle goes
// through read, check, the shared 32x32 multiplier, 45 root steps and
// accumulate, and a skipped one through read and check only; the vector sum
// then runs read, multiplier and root steps for its hypotenuse before the load.
// The store needs no clearing after reset; the input is not ready during
// the pass, and the result waits in an output register until taken.
`include "transverse_momentum_sums_unit_defines.svh"

module transverse_momentum_sums_unit
    import tms_pkg::*;
#(
    parameter int MAX_PARTICLES = 256
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [95:0]  i_s_tdata,   // mom_x, mom_y, energy, zero pad
    input  logic [32:0]  i_s_tuser,   // pdg_code, gen_status
    input  logic         i_s_tlast,   // last_particle
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    output logic [87:0]  o_m_tdata,   // vector_sum_mag, scalar_sum, zero pad
    output logic         o_m_tuser    // overflow
);

    localparam int CNT_W = $clog2(MAX_PARTICLES + 1);
    localparam int IDX_W = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
    localparam int SX_W  = MOM_W + CNT_W;
    localparam int SUM_W = MOM_W + 1 + CNT_W;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD   = 3'd1;
    localparam logic [2:0] S_CHK  = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_SQRT = 3'd4;
    localparam logic [2:0] S_ACC  = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;

    localparam logic [2:0] PP_LAST = 3'd6;
    localparam logic [5:0] STEP_LAST = 6'(ROOT_W - 1);

    t_particle r_mem [MAX_PARTICLES];
    t_particle r_rd;

    logic [2:0]           r_state;
    logic [CNT_W-1:0]     r_count;
    logic [CNT_W-1:0]     r_idx;
    logic [ENERGY_W-1:0]  r_max_ele;
    logic [ENERGY_W-1:0]  r_max_pos;
    logic                 r_drop;
    logic                 r_vec_mode;
    logic signed [SX_W-1:0] r_sx;
    logic signed [SX_W-1:0] r_sy;
    logic [SUM_W-1:0]     r_ssum;
    logic [OP_W-1:0]      r_op_a;
    logic [OP_W-1:0]      r_op_b;
    logic [2:0]           r_pp;
    logic [63:0]          r_prod;
    logic [1:0]           r_prod_part;
    logic [SQ_W-1:0]      r_rad;
    logic [REM_W-1:0]     r_rem;
    logic [ROOT_W-1:0]    r_root;
    logic [5:0]           r_step;
    logic                 r_out_valid;
    logic [OUT_W-1:0]     r_vmag;
    logic [OUT_W-1:0]     r_ssum_out;
    logic                 r_ovf;

    logic signed [PDG_W-1:0] in_code;
    logic [STATUS_W-1:0]     in_status;
    t_particle               in_part;
    logic                    in_acc;
    logic [MOM_W-1:0]        mag_x;
    logic [MOM_W-1:0]        mag_y;
    logic [SX_W-1:0]         mag_sx;
    logic [SX_W-1:0]         mag_sy;
    logic [OP_W-1:0]         mul_op;
    logic [1:0]              mul_part;
    logic [MOM_W-1:0]        mul_hi;
    logic [MOM_W-1:0]        mul_a;
    logic [MOM_W-1:0]        mul_b;
    logic [SQ_W-1:0]         pp_shifted;
    logic [REM_W-1:0]        rem_sh;
    logic [REM_W-1:0]        trial;
    logic                    out_load;

    assign in_code   = i_s_tuser[PDG_W-1:0];
    assign in_status = i_s_tuser[PDG_W+STATUS_W-1:PDG_W];
    assign in_part   = i_s_tdata[MOM_W*2+ENERGY_W-1:0];
    assign in_acc    = i_s_tvalid && o_s_tready;

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {6'd0, r_ssum_out, r_vmag};
    assign o_m_tuser  = r_ovf;

    assign mag_x  = r_rd.px[MOM_W-1] ? (MOM_W'(0) - r_rd.px) : r_rd.px;
    assign mag_y  = r_rd.py[MOM_W-1] ? (MOM_W'(0) - r_rd.py) : r_rd.py;
    assign mag_sx = r_sx[SX_W-1] ? (SX_W'(0) - SX_W'(r_sx)) : SX_W'(r_sx);
    assign mag_sy = r_sy[SX_W-1] ? (SX_W'(0) - SX_W'(r_sy)) : SX_W'(r_sy);

    // Shared multiplier: pp 0..2 square the first operand, 3..5 the second.
    always_comb begin
        mul_op   = (r_pp < 3'd3) ? r_op_a : r_op_b;
        mul_part = (r_pp < 3'd3) ? r_pp[1:0] : 2'(r_pp - 3'd3);
        mul_hi   = MOM_W'(mul_op[OP_W-1:MOM_W]);
        case (mul_part)
            PART_LL: begin
                mul_a = mul_op[MOM_W-1:0];
                mul_b = mul_op[MOM_W-1:0];
            end
            PART_HL: begin
                mul_a = mul_hi;
                mul_b = mul_op[MOM_W-1:0];
            end
            default: begin
                mul_a = mul_hi;
                mul_b = mul_hi;
            end
        endcase
        case (r_prod_part)
            PART_LL: pp_shifted = SQ_W'(r_prod);
            PART_HL: pp_shifted = SQ_W'(r_prod) << SH_HL;
            default: pp_shifted = SQ_W'(r_prod) << SH_HH;
        endcase
    end

    // One step of the restoring square root: two radicand bits a cycle.
    assign rem_sh = {r_rem[REM_W-3:0], r_rad[SQ_W-1:SQ_W-2]};
    assign trial  = REM_W'({r_root, 2'b01});

    assign out_load = (r_state == S_OUT) && (!r_out_valid || i_m_tready);

    always_ff @(posedge i_clk) begin
        if (in_acc && in_status == STATUS_FINAL && r_count < CNT_W'(MAX_PARTICLES)) begin
            r_mem[r_count[IDX_W-1:0]] <= in_part;
        end
        r_rd <= r_mem[r_idx[IDX_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_max_ele   <= '0;
            r_max_pos   <= '0;
            r_drop      <= 1'b0;
            r_out_valid <= 1'b0;
            r_idx       <= '0;
            r_pp        <= '0;
            r_step      <= '0;
        end else begin
            if (r_out_valid && i_m_tready && !out_load) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        if (in_status == STATUS_FINAL) begin
                            if (r_count < CNT_W'(MAX_PARTICLES)) begin
                                r_count <= r_count + 1'b1;
                            end else begin
                                r_drop <= 1'b1;
                            end
                            if (in_code == PDG_ELECTRON && in_part.energy > r_max_ele) begin
                                r_max_ele <= in_part.energy;
                            end
                            if (in_code == PDG_POSITRON && in_part.energy > r_max_pos) begin
                                r_max_pos <= in_part.energy;
                            end
                        end
                        if (i_s_tlast) begin
                            r_idx   <= '0;
                            r_sx    <= '0;
                            r_sy    <= '0;
                            r_ssum  <= '0;
                            r_state <= S_RD;
                        end
                    end
                end
                S_RD: begin
                    if (r_idx == r_count) begin
                        r_op_a     <= OP_W'(mag_sx);
                        r_op_b     <= OP_W'(mag_sy);
                        r_vec_mode <= 1'b1;
                        r_pp       <= '0;
                        r_rad      <= '0;
                        r_state    <= S_MUL;
                    end else begin
                        r_state <= S_CHK;
                    end
                end
                S_CHK: begin
                    if (r_rd.energy == r_max_ele || r_rd.energy == r_max_pos) begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= S_RD;
                    end else begin
                        r_op_a     <= OP_W'(mag_x);
                        r_op_b     <= OP_W'(mag_y);
                        r_sx       <= r_sx + SX_W'($signed(r_rd.px));
                        r_sy       <= r_sy + SX_W'($signed(r_rd.py));
                        r_vec_mode <= 1'b0;
                        r_pp       <= '0;
                        r_rad      <= '0;
                        r_state    <= S_MUL;
                    end
                end
                S_MUL: begin
                    // The product is registered and added in the next cycle.
                    r_prod      <= mul_a * mul_b;
                    r_prod_part <= mul_part;
                    if (r_pp != 3'd0) begin
                        r_rad <= r_rad + pp_shifted;
                    end
                    if (r_pp == PP_LAST) begin
                        r_rem   <= '0;
                        r_root  <= '0;
                        r_step  <= '0;
                        r_state <= S_SQRT;
                    end else begin
                        r_pp <= r_pp + 1'b1;
                    end
                end
                S_SQRT: begin
                    r_rad <= r_rad << 2;
                    if (rem_sh >= trial) begin
                        r_rem  <= rem_sh - trial;
                        r_root <= {r_root[ROOT_W-2:0], 1'b1};
                    end else begin
                        r_rem  <= rem_sh;
                        r_root <= {r_root[ROOT_W-2:0], 1'b0};
                    end
                    if (r_step == STEP_LAST) begin
                        r_state <= S_ACC;
                    end else begin
                        r_step <= r_step + 1'b1;
                    end
                end
                S_ACC: begin
                    if (r_vec_mode) begin
                        r_state <= S_OUT;
                    end else begin
                        r_ssum  <= r_ssum + SUM_W'(r_root);
                        r_idx   <= r_idx + 1'b1;
                        r_state <= S_RD;
                    end
                end
                S_OUT: begin
                    if (out_load) begin
                        r_out_valid <= 1'b1;
                        r_count     <= '0;
                        r_max_ele   <= '0;
                        r_max_pos   <= '0;
                        r_drop      <= 1'b0;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Result payload, saturated to the output width.
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_vmag     <= (64'(r_root) > OUT_MAX64) ? OUT_MAX : OUT_W'(r_root);
            r_ssum_out <= (64'(r_ssum) > OUT_MAX64) ? OUT_MAX : OUT_W'(r_ssum);
            r_ovf      <= r_drop;
        end
    end

    `TMS_CHECK(a_count_bound, 1'b1, r_count <= CNT_W'(MAX_PARTICLES))
    `TMS_CHECK(a_idx_bound, r_state != S_IDLE, r_idx <= r_count)
    `TMS_CHECK(a_step_bound, r_state == S_SQRT, r_step <= STEP_LAST)
    `TMS_CHECK_NEXT(a_event_cleared, out_load, r_count == '0 && !r_drop && r_out_valid)

endmodule
